/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers: concurrent checks that vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/swdb_pkg.sv */
// ----------------------------------------------------------------------------
// swdb_pkg
// Shared types, codes and helpers of the switch scan debouncer.
// ----------------------------------------------------------------------------
package swdb_pkg;

	localparam int TimerWidth    = 16;
	localparam int RegWidth      = 16;
	localparam int AdvTicksWidth = 7;   // 65535 / 1000 fits in 7 bits

	// reciprocal of 1000 scaled by 2**26, exact floor for 16-bit values
	localparam int RecipShift = 26;
	localparam logic [16:0] Recip1000 = 17'd67109;

	localparam logic [RegWidth-1:0] ScanReset     = 16'd50;
	localparam logic [RegWidth-1:0] DebounceReset = 16'd20;
	localparam int AdvanceResetUs = 50;
	localparam int LongAdvanceUs  = 1000;
	localparam logic [AdvTicksWidth-1:0] AdvTicksReset =
		AdvTicksWidth'(AdvanceResetUs / LongAdvanceUs);

	typedef logic [TimerWidth-1:0] timer_t;

	typedef enum logic [2:0] {
		REG_SCAN_PERIOD     = 3'd0,
		REG_SETTLE_TIME     = 3'd1,
		REG_PULL_ADVANCE_US = 3'd2,
		REG_NORMALLY_CLOSED = 3'd3,
		REG_PULL_SELECT     = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		SEL_NONE     = 3'd0,
		SEL_UP       = 3'd1,
		SEL_UP_DYN   = 3'd2,
		SEL_DOWN     = 3'd3,
		SEL_DOWN_DYN = 3'd4
	} pull_sel_t;

	typedef enum logic [1:0] {
		PULL_NONE = 2'd0,
		PULL_UP   = 2'd1,
		PULL_DOWN = 2'd2
	} pull_t;

	typedef enum logic [1:0] {
		EVT_NONE   = 2'd0,
		EVT_CLOSED = 2'd1,
		EVT_OPENED = 2'd2
	} event_t;

	typedef struct packed {
		logic [RegWidth-1:0]      scan_period;
		logic [RegWidth-1:0]      settle_time;
		logic [AdvTicksWidth-1:0] adv_ticks;
		logic                     normally_closed;
		logic [2:0]               pull_select;
	} cfg_t;

	typedef struct packed {
		logic   debounced_level;
		logic   deadline_armed;
		timer_t debounce_remaining;
		timer_t ticks_to_next_run;
		logic   pull_phase_pending;
	} state_t;

	typedef struct packed {
		pull_t  pull_mode;
		logic   pull_pulse;
		event_t event_code;
		logic   switch_active;
	} result_t;

	function automatic pull_t pull_of(logic [2:0] sel);
		pull_t p;
		p = PULL_NONE;
		unique case (sel)
			SEL_UP, SEL_UP_DYN:     p = PULL_UP;
			SEL_DOWN, SEL_DOWN_DYN: p = PULL_DOWN;
			default:                p = PULL_NONE;
		endcase
		return p;
	endfunction

	function automatic logic is_dynamic(logic [2:0] sel);
		return (sel == SEL_UP_DYN) || (sel == SEL_DOWN_DYN);
	endfunction

	// next run after a delay of d ticks: zero delay runs at the following tick
	function automatic timer_t sched(timer_t d);
		return (d == '0) ? '0 : timer_t'(d - timer_t'(1));
	endfunction

endpackage

/* src/swdb_cfg.sv */
// ----------------------------------------------------------------------------
// swdb_cfg
// Configuration registers; pull advance kept as whole ticks.
// ----------------------------------------------------------------------------
module swdb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [2:0]                    cfg_index,
	input  logic [swdb_pkg::RegWidth-1:0] cfg_data,
	output swdb_pkg::cfg_t                cfg,
	output logic                          phase_load,
	output logic                          phase_value
);

	logic [swdb_pkg::RegWidth+16:0]        adv_prod;
	logic [swdb_pkg::AdvTicksWidth-1:0]    adv_ticks_new;
	swdb_pkg::cfg_t                        cfg_q;

	// divide by 1000 through the scaled reciprocal
	assign adv_prod      = {1'b0, cfg_data} * {16'd0, swdb_pkg::Recip1000};
	assign adv_ticks_new = adv_prod[swdb_pkg::RecipShift +: swdb_pkg::AdvTicksWidth];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_period     <= swdb_pkg::ScanReset;
			cfg_q.settle_time     <= swdb_pkg::DebounceReset;
			cfg_q.adv_ticks       <= swdb_pkg::AdvTicksReset;
			cfg_q.normally_closed <= 1'b0;
			cfg_q.pull_select     <= swdb_pkg::SEL_NONE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				swdb_pkg::REG_SCAN_PERIOD:     cfg_q.scan_period     <= cfg_data;
				swdb_pkg::REG_SETTLE_TIME:     cfg_q.settle_time     <= cfg_data;
				swdb_pkg::REG_PULL_ADVANCE_US: cfg_q.adv_ticks       <= adv_ticks_new;
				swdb_pkg::REG_NORMALLY_CLOSED: cfg_q.normally_closed <= cfg_data[0];
				swdb_pkg::REG_PULL_SELECT:     cfg_q.pull_select     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// a new pull select rearms the pull phase for long dynamic advance
	assign phase_load  = cfg_write && (cfg_index == swdb_pkg::REG_PULL_SELECT);
	assign phase_value = swdb_pkg::is_dynamic(cfg_data[2:0]) && (cfg_q.adv_ticks != '0);

	assign cfg = cfg_q;

endmodule

/* src/swdb_step.sv */
// ----------------------------------------------------------------------------
// swdb_step
// Per-tick scan, debounce and pull decision.
// ----------------------------------------------------------------------------
module swdb_step (
	input  swdb_pkg::cfg_t    cfg,
	input  swdb_pkg::state_t  st,
	input  logic              pin_level,
	output swdb_pkg::state_t  st_next,
	output swdb_pkg::result_t res
);

	logic            dyn;
	logic            long_adv;
	logic            sample;
	swdb_pkg::pull_t lut;
	swdb_pkg::timer_t rem_dec;

	assign dyn      = swdb_pkg::is_dynamic(cfg.pull_select);
	assign long_adv = (cfg.adv_ticks != '0);
	assign lut      = swdb_pkg::pull_of(cfg.pull_select);
	assign sample   = pin_level ^ cfg.normally_closed;
	assign rem_dec  = (st.deadline_armed && (st.debounce_remaining != '0))
		? swdb_pkg::timer_t'(st.debounce_remaining - swdb_pkg::timer_t'(1))
		: st.debounce_remaining;

	always_comb begin
		st_next                    = st;
		st_next.debounce_remaining = rem_dec;
		res.pull_mode              = swdb_pkg::PULL_NONE;
		res.pull_pulse             = 1'b0;
		res.event_code             = swdb_pkg::EVT_NONE;

		if (st.ticks_to_next_run != '0) begin
			// idle tick: count down, keep static or long-phase pull
			st_next.ticks_to_next_run =
				swdb_pkg::timer_t'(st.ticks_to_next_run - swdb_pkg::timer_t'(1));
			if (!dyn || (long_adv && !st.pull_phase_pending))
				res.pull_mode = lut;
		end else if (st.pull_phase_pending) begin
			res.pull_mode              = lut;
			st_next.pull_phase_pending = 1'b0;
			st_next.ticks_to_next_run  =
				swdb_pkg::sched(swdb_pkg::timer_t'(cfg.adv_ticks));
		end else begin
			res.pull_mode  = lut;
			res.pull_pulse = dyn && !long_adv;
			if (dyn && long_adv)
				st_next.pull_phase_pending = 1'b1;
			if (sample != st.debounced_level) begin
				if (!st.deadline_armed) begin
					st_next.deadline_armed     = 1'b1;
					st_next.debounce_remaining = swdb_pkg::timer_t'(cfg.settle_time);
					st_next.ticks_to_next_run  =
						swdb_pkg::sched(swdb_pkg::timer_t'(cfg.settle_time));
				end else if (rem_dec == '0) begin
					st_next.debounced_level   = sample;
					st_next.deadline_armed    = 1'b0;
					res.event_code = sample ? swdb_pkg::EVT_CLOSED : swdb_pkg::EVT_OPENED;
					st_next.ticks_to_next_run =
						swdb_pkg::sched(swdb_pkg::timer_t'(cfg.scan_period));
				end else begin
					st_next.ticks_to_next_run =
						swdb_pkg::sched(swdb_pkg::timer_t'(cfg.scan_period));
				end
			end else begin
				st_next.deadline_armed     = 1'b0;
				st_next.debounce_remaining = '0;
				st_next.ticks_to_next_run  =
					swdb_pkg::sched(swdb_pkg::timer_t'(cfg.scan_period));
			end
		end

		res.switch_active = st_next.debounced_level;
	end

endmodule

/* src/switch_scan_debouncer.sv */
// ----------------------------------------------------------------------------
// switch_scan_debouncer
// Scan-scheduled switch debouncer with pull resistor control.
// ----------------------------------------------------------------------------
// Feed one input transfer per millisecond tick carrying the raw pin level.
// Every accepted tick yields exactly one result transfer: the pull to drive,
// the short-pulse flag, an open/close event and the debounced level.
// Input channel: in_valid / in_stall / pin_level. Output channel:
// out_valid / out_stall / pull_mode / pull_pulse / event_code / switch_active.
// The tick's state update and result are computed in one combinational
// pass and land in the output register at the accept edge.
// Throughput is one tick per cycle while out_stall is low; the single output
// register is refilled in the same cycle it is taken.
// A stall on the output holds the result and raises in_stall until the
// result is taken; no tick is dropped.
// Reset clears the debounce state, the scan schedule (first tick scans) and
// loads the default registers. Registers are written through cfg_write,
// cfg_index and cfg_data while no tick is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module switch_scan_debouncer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [2:0]                    cfg_index,
	input  logic [swdb_pkg::RegWidth-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          pin_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    pull_mode,
	output logic                          pull_pulse,
	output logic [1:0]                    event_code,
	output logic                          switch_active
);

	swdb_pkg::cfg_t    cfg;
	logic              phase_load;
	logic              phase_value;
	swdb_pkg::state_t  st_q;
	swdb_pkg::state_t  st_next;
	swdb_pkg::result_t res;
	swdb_pkg::result_t res_q;
	logic              out_valid_q;
	logic              in_xfer;

	swdb_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cfg         (cfg),
		.phase_load  (phase_load),
		.phase_value (phase_value)
	);

	swdb_step u_step (
		.cfg       (cfg),
		.st        (st_q),
		.pin_level (pin_level),
		.st_next   (st_next),
		.res       (res)
	);

	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (phase_load) begin
			st_q.pull_phase_pending <= phase_value;
		end else if (in_xfer) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign pull_mode     = res_q.pull_mode;
	assign pull_pulse    = res_q.pull_pulse;
	assign event_code    = res_q.event_code;
	assign switch_active = res_q.switch_active;

	// an event always reports the level it moved to
	`ASSERT_ALWAYS(a_event_level, clk, arst_n,
		!out_valid_q || (res_q.event_code != swdb_pkg::EVT_CLOSED) || res_q.switch_active)
	`ASSERT_ALWAYS(a_open_level, clk, arst_n,
		!out_valid_q || (res_q.event_code != swdb_pkg::EVT_OPENED) || !res_q.switch_active)
	// a short pulse only with a real pull
	`ASSERT_ALWAYS(a_pulse_pull, clk, arst_n,
		!out_valid_q || !res_q.pull_pulse || (res_q.pull_mode != swdb_pkg::PULL_NONE))
	// an accepted change leaves the deadline disarmed
	`ASSERT_NEXT(a_event_disarm, clk, arst_n,
		in_xfer && !phase_load && (res.event_code != swdb_pkg::EVT_NONE),
		!st_q.deadline_armed)

endmodule

/* verif/switch_scan_debouncer_tb.sv */
// ----------------------------------------------------------------------------
// switch_scan_debouncer_tb
// Self-checking bench for the scan-scheduled switch debouncer.
// ----------------------------------------------------------------------------
// A software copy of the debouncer tracks debounced level, deadline and scan
// schedule for every accepted tick and queues the result that the tick must
// give. Results leaving the block are matched in order, field by field.
// Stimulus starts with hand-built sequences (reset timing, zero delays, both
// events, inverted switches, short and long dynamic pull, unused selector
// codes, ignored register bits) and goes on with random register settings
// and pin patterns that hold each level for up to about one debounce window,
// with some bounce mixed in. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module switch_scan_debouncer_tb;

	// index with no register behind it
	localparam logic [2:0] REG_SPARE = 3'd7;

	class debounce_tracker;
		// register copies
		logic [swdb_pkg::RegWidth-1:0] scan_ticks;
		logic [swdb_pkg::RegWidth-1:0] debounce_ticks;
		logic [swdb_pkg::RegWidth-1:0] advance_us;
		logic                          invert;
		logic [2:0]                    sel;
		// debouncer state
		logic             level;
		logic             armed;
		swdb_pkg::timer_t remaining;
		swdb_pkg::timer_t countdown;
		logic             pull_pending;

		swdb_pkg::result_t tick_results[$];
		int                mismatches;
		int                ticks;

		function new();
			scan_ticks     = swdb_pkg::ScanReset;
			debounce_ticks = swdb_pkg::DebounceReset;
			advance_us     = swdb_pkg::RegWidth'(swdb_pkg::AdvanceResetUs);
			invert         = 1'b0;
			sel            = swdb_pkg::SEL_NONE;
			level          = 1'b0;
			armed          = 1'b0;
			remaining      = '0;
			countdown      = '0;
			pull_pending   = 1'b0;
			mismatches     = 0;
			ticks          = 0;
		endfunction

		function int pending();
			return tick_results.size();
		endfunction

		function logic sel_dynamic();
			return (sel == swdb_pkg::SEL_UP_DYN) || (sel == swdb_pkg::SEL_DOWN_DYN);
		endfunction

		// a delay of d ticks leaves d-1 idle ticks; zero runs again next tick
		function swdb_pkg::timer_t ticks_after(swdb_pkg::timer_t d);
			if (d == '0)
				return '0;
			return d - 1'b1;
		endfunction

		function void write_reg(logic [2:0] idx, logic [swdb_pkg::RegWidth-1:0] data);
			case (idx)
				swdb_pkg::REG_SCAN_PERIOD:     scan_ticks = data;
				swdb_pkg::REG_SETTLE_TIME:     debounce_ticks = data;
				swdb_pkg::REG_PULL_ADVANCE_US: advance_us = data;
				swdb_pkg::REG_NORMALLY_CLOSED: invert = data[0];
				swdb_pkg::REG_PULL_SELECT: begin
					sel = data[2:0];
					pull_pending = sel_dynamic() && (advance_us >= swdb_pkg::LongAdvanceUs);
				end
				default: ;
			endcase
		endfunction

		function void take_tick(logic pin);
			swdb_pkg::pull_t  lut;
			swdb_pkg::pull_t  mode;
			logic             pulse;
			swdb_pkg::event_t ev;
			logic             dyn;
			logic             long_adv;
			logic             s;

			ticks++;
			case (sel)
				swdb_pkg::SEL_UP, swdb_pkg::SEL_UP_DYN:     lut = swdb_pkg::PULL_UP;
				swdb_pkg::SEL_DOWN, swdb_pkg::SEL_DOWN_DYN: lut = swdb_pkg::PULL_DOWN;
				default:                                    lut = swdb_pkg::PULL_NONE;
			endcase
			mode     = swdb_pkg::PULL_NONE;
			pulse    = 1'b0;
			ev       = swdb_pkg::EVT_NONE;
			dyn      = sel_dynamic();
			long_adv = advance_us >= swdb_pkg::LongAdvanceUs;

			if (armed && remaining != '0)
				remaining = remaining - 1'b1;

			if (countdown != '0) begin
				countdown = countdown - 1'b1;
				if (!dyn || (long_adv && !pull_pending))
					mode = lut;
			end else if (pull_pending) begin
				// separate pull phase ahead of the measuring tick
				mode         = lut;
				pull_pending = 1'b0;
				countdown    = ticks_after(
					swdb_pkg::timer_t'(advance_us / swdb_pkg::LongAdvanceUs));
			end else begin
				mode  = lut;
				pulse = dyn && !long_adv;
				if (dyn && long_adv)
					pull_pending = 1'b1;
				s = pin ^ invert;
				if (s != level) begin
					if (!armed) begin
						armed     = 1'b1;
						remaining = debounce_ticks;
						countdown = ticks_after(debounce_ticks);
					end else if (remaining == '0) begin
						level = s;
						armed = 1'b0;
						if (s)
							ev = swdb_pkg::EVT_CLOSED;
						else
							ev = swdb_pkg::EVT_OPENED;
						countdown = ticks_after(scan_ticks);
					end else begin
						countdown = ticks_after(scan_ticks);
					end
				end else begin
					armed     = 1'b0;
					remaining = '0;
					countdown = ticks_after(scan_ticks);
				end
			end
			tick_results.push_back(swdb_pkg::result_t'{mode, pulse, ev, level});
		endfunction

		function void compare_result(swdb_pkg::result_t got);
			swdb_pkg::result_t want;
			if (tick_results.size() == 0) begin
				$display("%0t: result with no tick outstanding, got %h", $time, got);
				mismatches++;
				return;
			end
			want = tick_results.pop_front();
			if (got.pull_mode !== want.pull_mode) begin
				$display("%0t: pull_mode expected %0d got %0d", $time,
					want.pull_mode, got.pull_mode);
				mismatches++;
			end
			if (got.pull_pulse !== want.pull_pulse) begin
				$display("%0t: pull_pulse expected %0d got %0d", $time,
					want.pull_pulse, got.pull_pulse);
				mismatches++;
			end
			if (got.event_code !== want.event_code) begin
				$display("%0t: event_code expected %0d got %0d", $time,
					want.event_code, got.event_code);
				mismatches++;
			end
			if (got.switch_active !== want.switch_active) begin
				$display("%0t: switch_active expected %0d got %0d", $time,
					want.switch_active, got.switch_active);
				mismatches++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_write = 1'b0;
	logic [2:0]                    cfg_index = '0;
	logic [swdb_pkg::RegWidth-1:0] cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          pin_level = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [1:0]                    pull_mode;
	logic                          pull_pulse;
	logic [1:0]                    event_code;
	logic                          switch_active;

	bit quiet_in = 1'b0;
	bit quiet_out = 1'b0;

	debounce_tracker sb = new();

	switch_scan_debouncer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pin_level    (pin_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pull_mode    (pull_mode),
		.pull_pulse   (pull_pulse),
		.event_code   (event_code),
		.switch_active(switch_active)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stall before each transfer
	initial begin
		int hold;
		@(posedge clk);
		forever begin
			hold = quiet_out ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid && !out_stall)
			sb.compare_result(swdb_pkg::result_t'{swdb_pkg::pull_t'(pull_mode), pull_pulse,
				swdb_pkg::event_t'(event_code), switch_active});
	end

	task automatic send_tick(input logic lvl);
		int gap;
		gap = quiet_in ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		pin_level <= lvl;
		do @(posedge clk); while (in_stall);
		sb.take_tick(lvl);
	endtask

	task automatic send_level(input logic lvl, input int count);
		repeat (count) send_tick(lvl);
	endtask

	// every tick gives a result, so an empty queue means the block is idle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx,
		input logic [swdb_pkg::RegWidth-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// levels held about one debounce window, with stray bounces
	task automatic drive_pattern(input int count, input bit noise_only);
		logic lvl;
		logic pin;
		int   hold;
		int   span;
		span = sb.scan_ticks + sb.debounce_ticks + 4;
		if (span > 80)
			span = 80;
		lvl  = 1'($urandom_range(0, 1));
		hold = $urandom_range(1, span);
		for (int i = 0; i < count; i++) begin
			if (hold == 0) begin
				lvl  = ~lvl;
				hold = $urandom_range(1, span);
			end
			pin = lvl;
			if (noise_only || $urandom_range(0, 9) == 0)
				pin = 1'($urandom_range(0, 1));
			send_tick(pin);
			hold--;
			if ($urandom_range(0, 39) == 0)
				wait_idle();
		end
	endtask

	task automatic random_settings();
		int r;
		if ($urandom_range(0, 1))
			write_reg(swdb_pkg::REG_SCAN_PERIOD, swdb_pkg::RegWidth'(
				($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6)));
		if ($urandom_range(0, 1))
			write_reg(swdb_pkg::REG_SETTLE_TIME, swdb_pkg::RegWidth'(
				($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8)));
		if ($urandom_range(0, 1)) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				write_reg(swdb_pkg::REG_PULL_ADVANCE_US, 16'hFFFF);
			else if (r <= 3)
				write_reg(swdb_pkg::REG_PULL_ADVANCE_US,
					swdb_pkg::RegWidth'(swdb_pkg::LongAdvanceUs));
			else if (r <= 10)
				write_reg(swdb_pkg::REG_PULL_ADVANCE_US,
					swdb_pkg::RegWidth'($urandom_range(0, swdb_pkg::LongAdvanceUs - 1)));
			else
				write_reg(swdb_pkg::REG_PULL_ADVANCE_US,
					swdb_pkg::RegWidth'($urandom_range(swdb_pkg::LongAdvanceUs + 1, 4999)));
		end
		if ($urandom_range(0, 1))
			write_reg(swdb_pkg::REG_NORMALLY_CLOSED, swdb_pkg::RegWidth'($urandom));
		if ($urandom_range(0, 1))
			write_reg(swdb_pkg::REG_PULL_SELECT, ($urandom_range(0, 5) == 0) ?
				swdb_pkg::RegWidth'($urandom) :
				swdb_pkg::RegWidth'($urandom_range(swdb_pkg::SEL_NONE, swdb_pkg::SEL_DOWN_DYN)));
		if ($urandom_range(0, 15) == 0)
			write_reg(REG_SPARE, swdb_pkg::RegWidth'($urandom));
	endtask

	initial begin
		int phase;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: first tick scans and arms the default debounce
		send_tick(1'b1);
		wait_idle();
		write_reg(swdb_pkg::REG_SCAN_PERIOD, 16'd1);
		send_level(1'b1, 21);

		// zero delays: both events and a bounce
		wait_idle();
		write_reg(swdb_pkg::REG_SCAN_PERIOD, 16'd0);
		write_reg(swdb_pkg::REG_SETTLE_TIME, 16'd0);
		write_reg(swdb_pkg::REG_PULL_SELECT, swdb_pkg::RegWidth'(swdb_pkg::SEL_UP));
		send_level(1'b0, 2);
		send_tick(1'b1);
		send_tick(1'b0);
		send_level(1'b1, 2);

		// normally closed switch
		wait_idle();
		write_reg(swdb_pkg::REG_NORMALLY_CLOSED, 16'd1);
		send_level(1'b1, 2);
		send_level(1'b0, 2);

		// short dynamic pull just below the long threshold
		wait_idle();
		write_reg(swdb_pkg::REG_PULL_ADVANCE_US,
			swdb_pkg::RegWidth'(swdb_pkg::LongAdvanceUs - 1));
		write_reg(swdb_pkg::REG_PULL_SELECT, swdb_pkg::RegWidth'(swdb_pkg::SEL_DOWN_DYN));
		send_tick(1'b0);
		send_level(1'b1, 2);

		// long dynamic pull at the threshold, then a zero advance
		wait_idle();
		write_reg(swdb_pkg::REG_PULL_ADVANCE_US, swdb_pkg::RegWidth'(swdb_pkg::LongAdvanceUs));
		write_reg(swdb_pkg::REG_PULL_SELECT, swdb_pkg::RegWidth'(swdb_pkg::SEL_UP_DYN));
		send_level(1'b0, 3);
		send_level(1'b1, 3);
		wait_idle();
		write_reg(swdb_pkg::REG_PULL_ADVANCE_US, 16'd0);
		send_level(1'b0, 2);

		// unused selector and index, bits above the register width
		wait_idle();
		write_reg(swdb_pkg::REG_PULL_SELECT, 16'hFFFF);
		write_reg(swdb_pkg::REG_NORMALLY_CLOSED, 16'hFFFE);
		write_reg(REG_SPARE, 16'hFFFF);
		write_reg(swdb_pkg::REG_SETTLE_TIME, 16'd3);
		send_level(1'b1, 5);
		send_level(1'b0, 5);

		// longest pull phase
		wait_idle();
		write_reg(swdb_pkg::REG_PULL_ADVANCE_US, 16'hFFFF);
		write_reg(swdb_pkg::REG_PULL_SELECT, swdb_pkg::RegWidth'(swdb_pkg::SEL_DOWN_DYN));
		send_level(1'b1, 70);

		phase = 0;
		while (sb.ticks < 500 && phase < 300) begin
			wait_idle();
			quiet_in  = ($urandom_range(0, 3) == 0);
			quiet_out = ($urandom_range(0, 3) == 0);
			random_settings();
			drive_pattern($urandom_range(20, 60), $urandom_range(0, 4) == 0);
			phase++;
		end

		// widest timers last, since the schedule cannot come back from them
		wait_idle();
		quiet_in  = 1'b0;
		quiet_out = 1'b0;
		write_reg(swdb_pkg::REG_SCAN_PERIOD, 16'hFFFF);
		write_reg(swdb_pkg::REG_SETTLE_TIME, 16'hFFFF);
		write_reg(swdb_pkg::REG_PULL_SELECT, swdb_pkg::RegWidth'(swdb_pkg::SEL_UP));
		drive_pattern(30, 1'b0);

		wait_idle();
		repeat (3) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d results never arrived", $time, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/swdb_pkg.sv
src/swdb_cfg.sv
src/swdb_step.sv
src/switch_scan_debouncer.sv
verif/switch_scan_debouncer_tb.sv
